// ===== hdl/sqb_pkg.sv =====
package sqb_pkg;

	// sizes of the block
	localparam int TEXTURE_SLOTS = 32;
	localparam int MAX_QUADS     = 1024;
	localparam int SINE_DEPTH    = 1024;

	localparam int SLOT_CNT_W = $clog2(TEXTURE_SLOTS + 1);
	localparam int SLOT_IDX_W = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
	localparam int QUAD_W     = $clog2(MAX_QUADS + 1);
	localparam int ROM_AW     = $clog2(SINE_DEPTH + 1);

	// configuration register
	localparam int               CFG_W     = 11;
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	// op codes
	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_BEGIN = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_BIND   = 2'd1;
	localparam logic [1:0] KIND_DRAW   = 2'd2;

	// quarter turn of the binary angle
	localparam logic [11:0] ANGLE_QTR = 12'd1024;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] size_w;
		logic signed [15:0] size_h;
		logic [15:0]        texture_id;
		logic [31:0]        color_rgba;
		logic [11:0]        rotation;
		logic [63:0]        tex_rect;
		logic [15:0]        depth;
	} item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               last;
		logic [11:0]        vertex_addr;
		logic signed [15:0] vert_x;
		logic signed [15:0] vert_y;
		logic [15:0]        vert_depth;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic [31:0]        vert_color;
		logic [4:0]         slot;
		logic [15:0]        bound_texture;
		logic [10:0]        batch_quads;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic       take;
		logic       clear_batch;
		logic       match;
		logic       find;
		logic       rom_cos;
		logic       cap_sin;
		logic       cap_cos;
		logic       mul;
		logic       load;
		logic [1:0] kind;
		logic       last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       need_flush;
		logic       batch_empty;
		logic       bind_done;
		logic       corner_last;
		logic       out_free;
	} status_t;

	typedef logic [15:0] sine_rom_t [0:SINE_DEPTH];

	// quarter-wave sine table in Q1.15, by a fixed-point Taylor series
	function automatic sine_rom_t build_sine();
		sine_rom_t       rom;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned e;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if ((n % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			e = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
			if (e > 64'd32768) begin
				e = 64'd32768;
			end
			rom[k] = e[15:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// ===== hdl/sqb_if.sv =====
// command stream into the block
interface sqb_item_if;
	logic            valid;
	logic            ready;
	sqb_pkg::item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// result stream out of the block
interface sqb_result_if;
	logic             valid;
	logic             ready;
	sqb_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sqb_dp.sv =====
module sqb_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sqb_pkg::CFG_W-1:0]    cfg_wdata,
	input  sqb_pkg::item_t               item,
	input  logic                         out_ready,
	input  sqb_pkg::cmd_t                cmd,
	output sqb_pkg::status_t             stat,
	output logic                         out_valid,
	output sqb_pkg::result_t             out_data
);

	localparam int CW = sqb_pkg::SLOT_CNT_W;
	localparam int IW = sqb_pkg::SLOT_IDX_W;
	localparam int QW = sqb_pkg::QUAD_W;
	localparam int AW = sqb_pkg::ROM_AW;
	localparam int NS = sqb_pkg::TEXTURE_SLOTS;

	sqb_pkg::item_t               item_q;
	logic [sqb_pkg::CFG_W-1:0]    cfg_q;
	logic [QW-1:0]                quads_q;
	logic [CW-1:0]                slots_q;
	logic [CW-1:0]                bidx_q;
	logic [1:0]                   corner_q;
	logic [15:0]                  slot_tab_q [NS];
	logic [NS-1:0]                hit_q;
	logic [4:0]                   slot_q;
	logic [15:0]                  rom_q;
	logic                         neg_q;
	logic signed [16:0]           sn_q;
	logic signed [16:0]           cs_q;
	logic signed [32:0]           wcs_q;
	logic signed [32:0]           wsn_q;
	logic signed [32:0]           hcs_q;
	logic signed [32:0]           hsn_q;
	sqb_pkg::result_t             out_q;
	logic                         out_valid_q;

	logic [QW-1:0]      limit;
	logic               out_free;
	logic [11:0]        ang;
	logic [AW-1:0]      idx_lin;
	logic [AW-1:0]      rom_idx;
	logic signed [16:0] rom_val;
	logic               hit_any;
	logic [4:0]         hit_idx;
	logic               right;
	logic               top;
	logic signed [17:0] cx2;
	logic signed [17:0] cy2;
	logic signed [35:0] vx;
	logic signed [35:0] vy;
	logic signed [35:0] rx;
	logic signed [35:0] ry;
	logic signed [16:0] px_sum;
	logic signed [16:0] py_sum;
	sqb_pkg::result_t   res;

	// clamp signed value into Q12.4 range
	function automatic logic [15:0] sat16(input logic signed [35:0] v);
		logic [15:0] r;
		if (v > 36'sd32767) begin
			r = 16'h7fff;
		end else if (v < -36'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// batch limit with out-of-range values clamped
	always_comb begin
		if (cfg_q == '0) begin
			limit = QW'(1);
		end else if (int'(cfg_q) > sqb_pkg::MAX_QUADS) begin
			limit = QW'(sqb_pkg::MAX_QUADS);
		end else begin
			limit = QW'(cfg_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// status to the controller
	always_comb begin
		stat.op          = item_q.op;
		stat.need_flush  = (quads_q >= limit) || (int'(slots_q) >= NS);
		stat.batch_empty = (quads_q == '0);
		stat.bind_done   = (bidx_q >= slots_q);
		stat.corner_last = (corner_q == 2'd3);
		stat.out_free    = out_free;
	end

	// sine table address from quadrant and fraction
	always_comb begin
		ang     = item_q.rotation + (cmd.rom_cos ? sqb_pkg::ANGLE_QTR : 12'd0);
		idx_lin = AW'((32'(ang[9:0]) * sqb_pkg::SINE_DEPTH) >> 10);
		if (ang[10]) begin
			rom_idx = AW'(sqb_pkg::SINE_DEPTH) - idx_lin;
		end else begin
			rom_idx = idx_lin;
		end
	end

	assign rom_val = $signed({1'b0, rom_q});

	// priority encode of the registered match vector
	always_comb begin
		hit_any = |hit_q;
		hit_idx = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				hit_idx = 5'(i);
			end
		end
	end

	// corner geometry
	always_comb begin
		right  = (corner_q == 2'd1) || (corner_q == 2'd2);
		top    = (corner_q == 2'd0) || (corner_q == 2'd1);
		cx2    = (18'(item_q.pos_x) <<< 1) + 18'(item_q.size_w);
		cy2    = (18'(item_q.pos_y) <<< 1) + 18'(item_q.size_h);
		vx     = (36'(cx2) <<< 15) + (right ? 36'(wcs_q) : -36'(wcs_q))
			- (top ? 36'(hsn_q) : -36'(hsn_q));
		vy     = (36'(cy2) <<< 15) + (right ? 36'(wsn_q) : -36'(wsn_q))
			+ (top ? 36'(hcs_q) : -36'(hcs_q));
		rx     = (vx + 36'sd32768) >>> 16;
		ry     = (vy + 36'sd32768) >>> 16;
		px_sum = 17'(item_q.pos_x) + (right ? 17'(item_q.size_w) : 17'sd0);
		py_sum = 17'(item_q.pos_y) + (top ? 17'(item_q.size_h) : 17'sd0);
	end

	// result assembly
	always_comb begin
		res      = '0;
		res.kind = cmd.kind;
		res.last = cmd.last;
		case (cmd.kind)
			sqb_pkg::KIND_VERTEX: begin
				res.vertex_addr = 12'({quads_q, corner_q});
				if (item_q.rotation == '0) begin
					res.vert_x = sat16(36'(px_sum));
					res.vert_y = sat16(36'(py_sum));
				end else begin
					res.vert_x = sat16(rx);
					res.vert_y = sat16(ry);
				end
				res.vert_depth = item_q.depth;
				res.tex_u      = right ? item_q.tex_rect[47:32] : item_q.tex_rect[15:0];
				res.tex_v      = top ? item_q.tex_rect[63:48] : item_q.tex_rect[31:16];
				res.vert_color = item_q.color_rgba;
				res.slot       = slot_q;
			end
			sqb_pkg::KIND_BIND: begin
				res.slot          = 5'(bidx_q);
				res.bound_texture = slot_tab_q[bidx_q[IW-1:0]];
			end
			sqb_pkg::KIND_DRAW: begin
				res.batch_quads = 11'(quads_q);
			end
			default: begin
				res.kind = cmd.kind;
			end
		endcase
	end

	// control counters, config and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= sqb_pkg::CFG_RESET;
			quads_q     <= '0;
			slots_q     <= '0;
			bidx_q      <= '0;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.take) begin
				bidx_q   <= '0;
				corner_q <= '0;
			end
			if (cmd.clear_batch) begin
				quads_q <= '0;
				slots_q <= '0;
			end
			if (cmd.find && item_q.texture_id != '0 && !hit_any) begin
				slots_q <= slots_q + CW'(1);
			end
			if (cmd.load && cmd.kind == sqb_pkg::KIND_BIND) begin
				bidx_q <= bidx_q + CW'(1);
			end
			if (cmd.load && cmd.kind == sqb_pkg::KIND_VERTEX) begin
				corner_q <= corner_q + 2'd1;
				if (corner_q == 2'd3) begin
					quads_q <= quads_q + QW'(1);
				end
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= item;
		end
		for (int i = 0; i < NS; i++) begin
			hit_q[i] <= cmd.match && (i < int'(slots_q)) && (slot_tab_q[i] == item_q.texture_id);
		end
		if (cmd.find) begin
			if (item_q.texture_id == '0) begin
				slot_q <= '0;
			end else if (hit_any) begin
				slot_q <= hit_idx;
			end else begin
				slot_q                       <= 5'(slots_q);
				slot_tab_q[slots_q[IW-1:0]] <= item_q.texture_id;
			end
		end
		rom_q <= sqb_pkg::SINE_ROM[rom_idx];
		neg_q <= ang[11];
		if (cmd.cap_sin) begin
			sn_q <= neg_q ? -rom_val : rom_val;
		end
		if (cmd.cap_cos) begin
			cs_q <= neg_q ? -rom_val : rom_val;
		end
		if (cmd.mul) begin
			wcs_q <= item_q.size_w * cs_q;
			wsn_q <= item_q.size_w * sn_q;
			hcs_q <= item_q.size_h * cs_q;
			hsn_q <= item_q.size_h * sn_q;
		end
		if (cmd.load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_slots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(slots_q) <= NS)
		else $error("slot count above table size");

	a_quads_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(quads_q) <= sqb_pkg::MAX_QUADS)
		else $error("quad count above maximum");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> out_free)
		else $error("result loaded over a pending transaction");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.kind == sqb_pkg::KIND_VERTEX && corner_q == 2'd3) |-> cmd.last)
		else $error("fourth vertex without last");

endmodule

// ===== hdl/sqb_ctrl.sv =====
module sqb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sqb_pkg::status_t  stat,
	output sqb_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FLUSH_BIND,
		S_FLUSH_DRAW,
		S_MATCH,
		S_FIND,
		S_SIN,
		S_COS,
		S_MUL,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					sqb_pkg::OP_DRAW: begin
						state_d = stat.need_flush ? S_FLUSH_BIND : S_MATCH;
					end
					sqb_pkg::OP_END: begin
						state_d = S_FLUSH_BIND;
					end
					sqb_pkg::OP_BEGIN: begin
						cmd.clear_batch = 1'b1;
						state_d         = S_IDLE;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_FLUSH_BIND: begin
				if (stat.batch_empty) begin
					cmd.clear_batch = 1'b1;
					state_d         = (stat.op == sqb_pkg::OP_DRAW) ? S_MATCH : S_IDLE;
				end else if (stat.bind_done) begin
					state_d = S_FLUSH_DRAW;
				end else if (stat.out_free) begin
					cmd.load = 1'b1;
					cmd.kind = sqb_pkg::KIND_BIND;
				end
			end
			S_FLUSH_DRAW: begin
				if (stat.out_free) begin
					cmd.load        = 1'b1;
					cmd.kind        = sqb_pkg::KIND_DRAW;
					cmd.last        = (stat.op == sqb_pkg::OP_END);
					cmd.clear_batch = 1'b1;
					state_d         = (stat.op == sqb_pkg::OP_DRAW) ? S_MATCH : S_IDLE;
				end
			end
			S_MATCH: begin
				cmd.match = 1'b1;
				state_d   = S_FIND;
			end
			S_FIND: begin
				cmd.find = 1'b1;
				state_d  = S_SIN;
			end
			S_SIN: begin
				cmd.cap_sin = 1'b1;
				cmd.rom_cos = 1'b1;
				state_d     = S_COS;
			end
			S_COS: begin
				cmd.cap_cos = 1'b1;
				state_d     = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.kind = sqb_pkg::KIND_VERTEX;
				if (stat.out_free) begin
					cmd.load = 1'b1;
					cmd.last = stat.corner_last;
					if (stat.corner_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (state_q == S_DECODE))
		else $error("accepted transaction not decoded");

	a_draw_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |=> (state_q == S_EMIT))
		else $error("products not followed by vertex output");

	a_find_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.find |-> $past(cmd.match))
		else $error("slot lookup without registered match");

endmodule

// ===== hdl/sprite_quad_batcher.sv =====
// channel   | dir | handshake      | payload
// items     | in  | valid/ready    | op, quad geometry, texture, colour, angle, rect, depth
// results   | out | valid/ready    | vertex, texture bind or draw command
// cfg       | in  | cfg_we         | max_batch_quads (cfg_wdata)
//
// a quad goes from acceptance back to idle through these steps, in order:
// decode, table match, slot lookup, two sine table reads, products, 4 vertices
// a flush emits one bind per bound slot, then leaves the binds and issues the draw
// the single output register limits results to one per cycle; stalls hold the flow
// arst_n clears the counters, state and output valid; max_batch_quads resets to 1024
module sprite_quad_batcher (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sqb_pkg::CFG_W-1:0]  cfg_wdata,
	sqb_item_if.sink                   items,
	sqb_result_if.source               results
);

	sqb_pkg::cmd_t    cmd;
	sqb_pkg::status_t stat;

	// sequencing
	sqb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, slot table and output register
	sqb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (items.data),
		.out_ready (results.ready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (results.valid),
		.out_data  (results.data)
	);

endmodule
